FILE: rtl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types and constants of the console byte parser: operation codes
// passed from the byte decoder to the cursor engine, result layout, states.
// ----------------------------------------------------------------------------
package cbp_pkg;

    // result kinds, as they leave on the master tuser
    typedef enum logic [2:0] {
        ACT_CURSOR = 3'd0,
        ACT_DRAW   = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_SCROLL = 3'd3,
        ACT_ESC    = 3'd4,
        ACT_CTRL   = 3'd5
    } t_action;

    // decoded operations queued between decoder and cursor engine
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PRINT = 3'd1,
        OP_CR    = 3'd2,
        OP_LF    = 3'd3,
        OP_TAB   = 3'd4,
        OP_BS    = 3'd5,
        OP_ESC   = 3'd6,
        OP_CTRL  = 3'd7
    } t_op_kind;

    // escape parser phase
    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_SEEN  = 2'd1,
        ESC_US    = 2'd2,
        ESC_DIGIT = 2'd3
    } t_esc_phase;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GLYPH_W  = 2'd0,
        CFG_GLYPH_H  = 2'd1,
        CFG_LINE_PX  = 2'd2,
        CFG_BUF_ROWS = 2'd3
    } t_cfg_idx;

    // cursor engine states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TWAIT,
        S_PCHK,
        S_NLA,
        S_NLB,
        S_NLC,
        S_NLD,
        S_NLE,
        S_DRAW
    } t_bstate;

    typedef struct packed {
        t_op_kind    kind;
        logic [20:0] cp;
        logic [3:0]  arg;
        logic [7:0]  letter;
    } t_op;

    // effective configuration (zero glyph sizes already mapped to one)
    typedef struct packed {
        logic [4:0] gw;
        logic [4:0] gh;
        logic [9:0] line_px;
        logic [7:0] rows;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [20:0] cp;
        logic [9:0]  x;
        logic [7:0]  y;
        logic [3:0]  arg;
        logic [7:0]  letter;
        logic        last;
    } t_result;

    // divider request and response
    typedef struct packed {
        logic       start;
        logic [9:0] dividend;
        logic [4:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [9:0] quo;
        logic [2:0] qmod;
    } t_div_rsp;

    localparam logic [7:0] CH_US    = 8'h5f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_ESC   = 8'h1b;

    localparam logic [7:0] UTF_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] MASK_CONT = 8'h3f;
    localparam logic [7:0] MASK_L4   = 8'h07;
    localparam logic [7:0] MASK_L3   = 8'h0f;
    localparam logic [7:0] MASK_L2   = 8'h1f;

endpackage

FILE: rtl/cbp_front.sv
// ----------------------------------------------------------------------------
// cbp_front
// Byte decoder: UTF-8 assembly and escape parsing; turns every accepted
// byte into exactly one queued operation.
// ----------------------------------------------------------------------------
module cbp_front import cbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_op        o_op
);

    t_esc_phase  r_esc, n_esc;
    logic [7:0]  r_digit, n_digit;
    logic [20:0] r_accum, n_accum;
    logic [2:0]  r_pend, n_pend;
    logic [7:0]  esc_arg;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;
    assign esc_arg = r_digit - CH_ZERO;

    // classify the byte and advance decoder state
    always_comb begin
        n_esc       = r_esc;
        n_digit     = r_digit;
        n_accum     = r_accum;
        n_pend      = r_pend;
        o_op.kind   = OP_NONE;
        o_op.cp     = '0;
        o_op.arg    = '0;
        o_op.letter = '0;
        if (accept) begin
            unique case (r_esc)
                ESC_SEEN: n_esc = (i_byte == CH_US) ? ESC_US : ESC_IDLE;
                ESC_US: begin
                    n_digit = i_byte;
                    n_esc   = ESC_DIGIT;
                end
                ESC_DIGIT: begin
                    n_esc = ESC_IDLE;
                    if (esc_arg <= 8'd9) begin
                        o_op.kind   = OP_ESC;
                        o_op.arg    = esc_arg[3:0];
                        o_op.letter = i_byte;
                    end
                end
                ESC_IDLE: begin
                    priority if (i_byte >= UTF_LEAD4) begin
                        n_accum = {13'd0, i_byte & MASK_L4};
                        n_pend  = 3'd4;
                    end else if (i_byte >= UTF_LEAD3) begin
                        n_accum = {13'd0, i_byte & MASK_L3};
                        n_pend  = 3'd3;
                    end else if (i_byte >= UTF_LEAD2) begin
                        n_accum = {13'd0, i_byte & MASK_L2};
                        n_pend  = 3'd2;
                    end else if (i_byte >= UTF_CONT) begin
                        // stray continuation bytes are dropped
                        if (r_pend >= 3'd2) begin
                            n_accum = {r_accum[14:0], i_byte[5:0] & MASK_CONT[5:0]};
                            n_pend  = r_pend - 3'd1;
                            if (r_pend == 3'd2) begin
                                n_pend    = 3'd0;
                                o_op.kind = OP_PRINT;
                                o_op.cp   = {r_accum[14:0], i_byte[5:0]};
                            end
                        end
                    end else if (i_byte >= CH_SPACE) begin
                        o_op.kind = OP_PRINT;
                        o_op.cp   = {13'd0, i_byte};
                    end else begin
                        priority case (i_byte)
                            CH_CR:  o_op.kind = OP_CR;
                            CH_LF:  o_op.kind = OP_LF;
                            CH_TAB: o_op.kind = OP_TAB;
                            CH_BS:  o_op.kind = OP_BS;
                            CH_ESC: n_esc     = ESC_SEEN;
                            default: begin
                                o_op.kind = OP_CTRL;
                                o_op.cp   = {13'd0, i_byte};
                            end
                        endcase
                    end
                end
                default: n_esc = ESC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ESC_IDLE;
            r_digit <= '0;
            r_accum <= '0;
            r_pend  <= '0;
        end else begin
            r_esc   <= n_esc;
            r_digit <= n_digit;
            r_accum <= n_accum;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: rtl/cbp_fifo.sv
// ----------------------------------------------------------------------------
// cbp_fifo
// Two-entry operation queue between byte decoder and cursor engine.
// ----------------------------------------------------------------------------
module cbp_fifo import cbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_op    = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

FILE: rtl/cbp_div.sv
// ----------------------------------------------------------------------------
// cbp_div
// Restoring divider, one quotient bit per cycle, also keeping the quotient
// modulo the tab stop as the bits arrive.
// ----------------------------------------------------------------------------
module cbp_div import cbp_pkg::*; #(
    parameter int TAB_STOP = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [9:0] r_dvd;
    logic [4:0] r_dsr;
    logic [4:0] r_rem;
    logic [2:0] r_qm;
    logic [3:0] r_cnt;
    logic       r_busy, r_done;
    logic [5:0] trial;
    logic       ge;
    logic [3:0] qm2;

    assign trial = {r_rem, r_dvd[9]};
    assign ge    = (trial >= {1'b0, r_dsr});
    assign qm2   = {r_qm, ge};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dvd;
    assign o_rsp.qmod = r_qm;

    // datapath step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
            r_qm  <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[8:0], ge};
            r_rem <= ge ? 5'(trial - {1'b0, r_dsr}) : trial[4:0];
            r_qm  <= (qm2 >= 4'(TAB_STOP)) ? 3'(qm2 - 4'(TAB_STOP)) : qm2[2:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd9) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/cbp_back.sv
// ----------------------------------------------------------------------------
// cbp_back
// Cursor engine: executes queued operations, tracks the pixel cursor and
// fills the output register with result beats.
// ----------------------------------------------------------------------------
module cbp_back import cbp_pkg::*; #(
    parameter int TAB_STOP = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_op_valid,
    input  t_op      i_op,
    output logic     o_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);

    t_bstate    r_state, n_state;
    logic [9:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    t_op        r_op, n_op;
    logic [3:0] r_cnt, n_cnt;
    logic       r_from_print, n_from_print;
    logic       r_scroll, n_scroll;
    logic [9:0] r_q1, n_q1;
    logic       r_ovalid, n_ovalid;
    t_result    r_out, n_out;
    logic       out_free, wrap, nle_need;

    assign out_free = !r_ovalid || i_ready;
    assign wrap     = ({1'b0, r_col} + {6'd0, i_cfg.gw}) > {1'b0, i_cfg.line_px};
    assign nle_need = r_scroll || !r_from_print;
    assign o_valid  = r_ovalid;
    assign o_res    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_op_valid) n_state = S_EXEC;
            S_EXEC: begin
                unique case (r_op.kind)
                    OP_PRINT: n_state = S_PCHK;
                    OP_TAB:   n_state = S_TWAIT;
                    OP_LF:    n_state = S_NLA;
                    default:  if (out_free) n_state = S_IDLE;
                endcase
            end
            S_TWAIT: if (i_div_rsp.done) n_state = S_PCHK;
            S_PCHK:  n_state = wrap ? S_NLA : S_DRAW;
            S_NLA:   n_state = S_NLB;
            S_NLB:   if (i_div_rsp.done) n_state = S_NLC;
            S_NLC:   n_state = S_NLD;
            S_NLD:   if (i_div_rsp.done) n_state = S_NLE;
            S_NLE: begin
                if (!nle_need || out_free) n_state = r_from_print ? S_DRAW : S_IDLE;
            end
            S_DRAW: begin
                if (out_free) n_state = (r_cnt == 4'd1) ? S_IDLE : S_PCHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result beats
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_op         = r_op;
        n_cnt        = r_cnt;
        n_from_print = r_from_print;
        n_scroll     = r_scroll;
        n_q1         = r_q1;
        n_ovalid     = r_ovalid && !i_ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_col;
        o_div_req.divisor  = i_cfg.gh;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_pop = 1'b1;
                    n_op  = i_op;
                end
            end
            S_EXEC: begin
                unique case (r_op.kind)
                    OP_PRINT: n_cnt = 4'd1;
                    OP_TAB: begin
                        o_div_req.start   = 1'b1;
                        o_div_req.divisor = i_cfg.gw;
                    end
                    OP_LF: n_from_print = 1'b0;
                    default: begin
                        if (out_free) begin
                            n_ovalid = 1'b1;
                            n_out    = '{ACT_CURSOR, 21'd0, r_col, r_row, 4'd0, 8'd0, 1'b1};
                            unique case (r_op.kind)
                                OP_CR: n_out.x = '0;
                                OP_ESC: begin
                                    n_out.action = ACT_ESC;
                                    n_out.arg    = r_op.arg;
                                    n_out.letter = r_op.letter;
                                end
                                OP_CTRL: begin
                                    n_out.action = ACT_CTRL;
                                    n_out.cp     = r_op.cp;
                                end
                                OP_BS: begin
                                    if (r_col >= {5'd0, i_cfg.gw}) begin
                                        n_out.action = ACT_ERASE;
                                        n_out.x      = r_col - {5'd0, i_cfg.gw};
                                    end
                                end
                                default: n_out.action = ACT_CURSOR;
                            endcase
                            n_col = n_out.x;
                        end
                    end
                endcase
            end
            S_TWAIT: begin
                if (i_div_rsp.done) begin
                    n_cnt   = 4'(TAB_STOP) - {1'b0, i_div_rsp.qmod};
                    n_op.cp = {13'd0, CH_SPACE};
                end
            end
            S_PCHK: if (wrap) n_from_print = 1'b1;
            S_NLA: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {2'd0, r_row};
            end
            S_NLB: if (i_div_rsp.done) n_q1 = i_div_rsp.quo;
            S_NLC: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {2'd0, i_cfg.rows};
            end
            S_NLD: begin
                if (i_div_rsp.done) begin
                    n_col = '0;
                    // the cursor sits on the last text row: scroll instead
                    if ((r_q1 + 10'd1) == i_div_rsp.quo) begin
                        n_scroll = 1'b1;
                    end else begin
                        n_scroll = 1'b0;
                        n_row    = r_row + {3'd0, i_cfg.gh};
                    end
                end
            end
            S_NLE: begin
                if (nle_need && out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{(r_scroll ? ACT_SCROLL : ACT_CURSOR), 21'd0, r_col,
                                 r_row, 4'd0, 8'd0, !r_from_print};
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{ACT_DRAW, r_op.cp, r_col, r_row, 4'd0, 8'd0,
                                 (r_cnt == 4'd1)};
                    n_col    = r_col + {5'd0, i_cfg.gw};
                    n_cnt    = r_cnt - 4'd1;
                end
            end
            default: n_ovalid = r_ovalid && !i_ready;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_q1   <= n_q1;
        r_out  <= n_out;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_from_print <= 1'b0;
            r_scroll     <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_from_print <= n_from_print;
            r_scroll     <= n_scroll;
            r_ovalid     <= n_ovalid;
        end
    end

endmodule

FILE: rtl/console_byte_parser.sv
// ----------------------------------------------------------------------------
// console_byte_parser
// Console byte stream to drawing commands: UTF-8 decode, cursor tracking.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the slave stream (tdata[7:0]). Each byte yields one
// to sixteen result beats on the master stream; tlast marks the final beat
// of a byte, tuser carries the action code. Registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// A decoder takes one byte per cycle into a two-entry queue while the
// queue is not full; the cursor engine then executes the queued operations.
// A line feed or a wrap runs two 10-step divisions on the shared serial
// divider; a tab runs one before its spaces.
// Reset clears the cursor, the UTF-8 and escape state, the queue and the
// output register, and loads the register defaults.
// When the receiver stalls, the output register holds its beat, the engine
// waits, and once the queue is full s_axis_tready drops.
// ----------------------------------------------------------------------------
module console_byte_parser import cbp_pkg::*; #(
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // code_point, pos_x, pos_y, esc_arg, esc_letter
    output logic [2:0]  m_axis_tuser,   // action
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);

    logic [4:0] r_gw, r_gh;
    logic [9:0] r_line;
    logic [7:0] r_rows;
    t_cfg       cfg;
    logic       q_full, q_valid, push, pop;
    t_op        op_in, op_out;
    t_div_req   div_req;
    t_div_rsp   div_rsp;
    t_result    res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= 5'd8;
            r_gh   <= 5'd16;
            r_line <= 10'd256;
            r_rows <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GLYPH_W:  r_gw   <= i_cfg_data[4:0];
                CFG_GLYPH_H:  r_gh   <= i_cfg_data[4:0];
                CFG_LINE_PX:  r_line <= i_cfg_data;
                CFG_BUF_ROWS: r_rows <= i_cfg_data[7:0];
                default:      r_rows <= r_rows;
            endcase
        end
    end

    // zero glyph size acts as one
    assign cfg.gw      = (r_gw == 5'd0) ? 5'd1 : r_gw;
    assign cfg.gh      = (r_gh == 5'd0) ? 5'd1 : r_gh;
    assign cfg.line_px = r_line;
    assign cfg.rows    = r_rows;

    cbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_q_full(q_full),
        .o_push  (push),
        .o_op    (op_in)
    );

    cbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_op    (op_out)
    );

    cbp_div #(.TAB_STOP(TAB_STOP)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    cbp_back #(.TAB_STOP(TAB_STOP)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op_valid (q_valid),
        .i_op       (op_out),
        .o_pop      (pop),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res)
    );

    // output beat packing
    assign m_axis_tdata = {5'd0, res.letter, res.arg, res.y, res.x, res.cp};
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;

endmodule

FILE: rtl/cbp_checker.sv
// ----------------------------------------------------------------------------
// cbp_checker
// Port-level checks of the console byte parser, bound to the top level.
// ----------------------------------------------------------------------------
module cbp_checker import cbp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [9:0]  i_cfg_data
);

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled beat changed");

    // cursor-only, erase, escape and control beats always close their byte
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_CURSOR || m_axis_tuser == ACT_ESC
            || m_axis_tuser == ACT_CTRL || m_axis_tuser == ACT_ERASE) |-> m_axis_tlast)
        else $error("single-beat action without tlast");

    // escape argument is a decimal digit
    a_esc_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_ESC |-> m_axis_tdata[42:39] <= 4'd9)
        else $error("escape argument out of range");

    // scroll beats come with the cursor at column zero
    a_scroll_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_SCROLL |-> m_axis_tdata[30:21] == 10'd0)
        else $error("scroll with non-zero column");

endmodule

bind console_byte_parser cbp_checker u_cbp_checker (.*);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// console byte parser testbench
// Drives console bytes on the slave stream and checks every result beat
// against a cycle-free model of the decoder and cursor held in this file.
// Directed bytes first, then random bytes across several register settings
// and idling phases.
// ----------------------------------------------------------------------------
module testbench;
    import cbp_pkg::*;

    typedef struct packed {
        logic [2:0]  act;
        logic [20:0] cp;
        logic [9:0]  x;
        logic [7:0]  y;
        logic [3:0]  arg;
        logic [7:0]  letter;
        logic        last;
    } t_beat;

    // directed stimulus row: byte, and optionally the expected first beat
    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_action    act;
        logic [20:0] cp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [9:0]  i_cfg_data = '0;

    console_byte_parser dut (.*);

    always #5 i_clk = ~i_clk;

    // model state
    logic [4:0] glyph_w, glyph_h;
    logic [9:0] line_px;
    logic [7:0] buf_rows;
    logic [9:0] col_px;
    logic [7:0] row_px;
    logic [20:0] accum;
    logic [2:0] pending;
    t_esc_phase esc_ph;
    logic [7:0] esc_dig;

    t_beat expected_beats[$];
    int    n_items, n_beats, n_bad, stall_cycles;
    int    send_idle_pct, recv_idle_pct;
    bit    timed_out;
    t_beat cur_byte[$];

    task automatic emit(input t_action a, input logic [20:0] cp,
                        input logic [3:0] arg, input logic [7:0] letter);
        t_beat bt;
        if (cur_byte.size() >= 16) return;
        bt.act = a; bt.cp = cp; bt.x = col_px; bt.y = row_px;
        bt.arg = arg; bt.letter = letter; bt.last = 1'b0;
        cur_byte.push_back(bt);
    endtask

    function automatic int eff_w();
        return (glyph_w == 0) ? 1 : glyph_w;
    endfunction

    function automatic int eff_h();
        return (glyph_h == 0) ? 1 : glyph_h;
    endfunction

    task automatic line_feed();
        int gh;
        gh = eff_h();
        col_px = '0;
        if (int'(row_px) / gh == int'(buf_rows) / gh - 1)
            emit(ACT_SCROLL, '0, '0, '0);
        else
            row_px = row_px + 8'(gh);
    endtask

    task automatic put_glyph(input logic [20:0] cp);
        int gw;
        gw = eff_w();
        if (int'(col_px) + gw > int'(line_px)) line_feed();
        emit(ACT_DRAW, cp, '0, '0);
        col_px = col_px + 10'(gw);
    endtask

    // work out the beats one byte causes and queue them
    task automatic predict_byte(input logic [7:0] b);
        int n, gw;
        logic [7:0] a;
        cur_byte.delete();
        if (esc_ph == ESC_SEEN) begin
            esc_ph = (b == CH_US) ? ESC_US : ESC_IDLE;
        end else if (esc_ph == ESC_US) begin
            esc_dig = b;
            esc_ph = ESC_DIGIT;
        end else if (esc_ph == ESC_DIGIT) begin
            a = esc_dig - CH_ZERO;
            esc_ph = ESC_IDLE;
            if (a <= 9) emit(ACT_ESC, '0, a[3:0], b);
        end else if (b >= UTF_CONT) begin
            if (b >= UTF_LEAD4) begin
                accum = 21'(b & MASK_L4); pending = 4;
            end else if (b >= UTF_LEAD3) begin
                accum = 21'(b & MASK_L3); pending = 3;
            end else if (b >= UTF_LEAD2) begin
                accum = 21'(b & MASK_L2); pending = 2;
            end else if (pending >= 2) begin
                accum = {accum[14:0], b[5:0]};
                pending = pending - 1;
                if (pending == 1) begin
                    pending = 0;
                    put_glyph(accum);
                end
            end
        end else if (b >= CH_SPACE) begin
            put_glyph(21'(b));
        end else begin
            case (b)
                CH_CR: col_px = '0;
                CH_LF: line_feed();
                CH_TAB: begin
                    gw = eff_w();
                    n = 8 - ((int'(col_px) / gw) % 8);
                    repeat (n) put_glyph(21'(CH_SPACE));
                end
                CH_ESC: esc_ph = ESC_SEEN;
                CH_BS: begin
                    gw = eff_w();
                    if (int'(col_px) >= gw) begin
                        col_px = col_px - 10'(gw);
                        emit(ACT_ERASE, '0, '0, '0);
                    end
                end
                default: emit(ACT_CTRL, 21'(b), '0, '0);
            endcase
        end
        if (cur_byte.size() == 0) emit(ACT_CURSOR, '0, '0, '0);
        cur_byte[cur_byte.size()-1].last = 1'b1;
        foreach (cur_byte[i]) expected_beats.push_back(cur_byte[i]);
    endtask

    // valid stays high into the next byte unless the sender idles
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [9:0] v);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        case (idx)
            CFG_GLYPH_W:  glyph_w = v[4:0];
            CFG_GLYPH_H:  glyph_h = v[4:0];
            CFG_LINE_PX:  line_px = v;
            CFG_BUF_ROWS: buf_rows = v[7:0];
        endcase
    endtask

    task automatic set_layout(input logic [9:0] gw, gh, lp, br);
        write_reg(CFG_GLYPH_W, gw);
        write_reg(CFG_GLYPH_H, gh);
        write_reg(CFG_LINE_PX, lp);
        write_reg(CFG_BUF_ROWS, br);
        i_cfg_we <= 1'b0;
    endtask

    // mostly printable text and utf-8 runs, some controls and escapes
    function automatic logic [7:0] rand_byte();
        int k;
        k = $urandom_range(99, 0);
        if (k < 35) return 8'($urandom_range(126, 32));
        if (k < 45) return 8'($urandom_range(191, 128));
        if (k < 55) return 8'($urandom_range(255, 192));
        if (k < 65) return CH_TAB;
        if (k < 72) return CH_LF;
        if (k < 77) return CH_BS;
        if (k < 80) return CH_CR;
        if (k < 85) return CH_ESC;
        if (k < 90) return CH_US;
        if (k < 95) return 8'($urandom_range(57, 48));
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_utf8();
        logic [20:0] cp;
        int len;
        len = $urandom_range(4, 2);
        cp = 21'($urandom);
        case (len)
            2: send_byte({3'b110, cp[10:6]});
            3: send_byte({4'b1110, cp[15:12]});
            default: send_byte({5'b11110, cp[20:18]});
        endcase
        if (len == 4) send_byte({2'b10, cp[17:12]});
        if (len >= 3) send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
    endtask

    task automatic random_phase(input int count);
        int k;
        k = 0;
        while (k < count) begin
            case ($urandom_range(9, 0))
                0, 1: begin send_utf8(); k += 3; end
                2: begin
                    send_byte(CH_ESC); send_byte(CH_US);
                    send_byte(8'($urandom_range(60, 46)));
                    send_byte(8'($urandom)); k += 4;
                end
                default: begin send_byte(rand_byte()); k++; end
            endcase
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats++;
            got.act = m_axis_tuser; got.cp = m_axis_tdata[20:0];
            got.x = m_axis_tdata[30:21]; got.y = m_axis_tdata[38:31];
            got.arg = m_axis_tdata[42:39]; got.letter = m_axis_tdata[50:43];
            got.last = m_axis_tlast;
            if (expected_beats.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected beat act=%0d cp=%h", got.act, got.cp);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch exp act=%0d cp=%h x=%0d y=%0d arg=%0d let=%h l=%b, got act=%0d cp=%h x=%0d y=%0d arg=%0d let=%h l=%b",
                            want.act, want.cp, want.x, want.y, want.arg, want.letter,
                            want.last, got.act, got.cp, got.x, got.y, got.arg,
                            got.letter, got.last);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row rows[] = '{
        '{8'h41, 1, ACT_DRAW, 21'h41},
        '{8'h7f, 1, ACT_DRAW, 21'h7f},
        '{8'h00, 1, ACT_CTRL, 21'h00},
        '{8'h1f, 1, ACT_CTRL, 21'h1f},
        '{8'h80, 1, ACT_CURSOR, 21'h0},
        '{8'hc3, 1, ACT_CURSOR, 21'h0},
        '{8'ha9, 0, ACT_CURSOR, 21'h0},
        '{8'he2, 0, ACT_CURSOR, 21'h0},
        '{8'h82, 0, ACT_CURSOR, 21'h0},
        '{8'h41, 0, ACT_CURSOR, 21'h0},
        '{8'hf0, 0, ACT_CURSOR, 21'h0},
        '{8'hff, 0, ACT_CURSOR, 21'h0},
        '{8'hbf, 0, ACT_CURSOR, 21'h0},
        '{8'hbf, 0, ACT_CURSOR, 21'h0},
        '{8'hbf, 0, ACT_CURSOR, 21'h0},
        '{8'h09, 0, ACT_CURSOR, 21'h0},
        '{8'h08, 1, ACT_ERASE, 21'h0},
        '{8'h0d, 1, ACT_CURSOR, 21'h0},
        '{8'h08, 1, ACT_CURSOR, 21'h0},
        '{8'h0a, 0, ACT_CURSOR, 21'h0},
        '{8'h1b, 1, ACT_CURSOR, 21'h0},
        '{8'h5f, 1, ACT_CURSOR, 21'h0},
        '{8'h37, 1, ACT_CURSOR, 21'h0},
        '{8'h6b, 1, ACT_ESC, 21'h0},
        '{8'h1b, 0, ACT_CURSOR, 21'h0}
    };

    initial begin
        glyph_w = 8; glyph_h = 16; line_px = 256; buf_rows = 16;
        col_px = '0; row_px = '0; accum = '0; pending = '0;
        esc_ph = ESC_IDLE; esc_dig = '0;
        n_items = 0; n_beats = 0; n_bad = 0; stall_cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0; timed_out = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: typed rows check the action and code of their first beat
        foreach (rows[i]) begin
            send_byte(rows[i].b);
            if (rows[i].typed && (cur_byte.size() == 0 ||
                    cur_byte[0].act != rows[i].act ||
                    cur_byte[0].cp != rows[i].cp)) begin
                n_bad++;
                $display("directed row %0d: model disagrees with table", i);
            end
        end
        send_byte(8'h41); // ends escape; yields only a cursor beat
        drain();

        // settings and idling phases, extremes included
        set_layout(10'd0, 10'd0, 10'd16, 10'd1);
        random_phase(30);
        drain();
        send_idle_pct = 72;
        set_layout(10'd16, 10'd16, 10'd1023, 10'd255);
        random_phase(40);
        drain();
        send_idle_pct = 0; recv_idle_pct = 72;
        set_layout(10'd5, 10'd3, 10'd40, 10'd20);
        random_phase(40);
        drain();
        send_idle_pct = 37; recv_idle_pct = 37;
        set_layout(10'd1, 10'd1, 10'd16, 10'd255);
        random_phase(30);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        set_layout(10'd7, 10'd9, 10'd100, 10'd8);
        random_phase(40);
        drain();

        $display("%0d bytes sent, %0d result beats checked over six register settings",
            n_items, n_beats);
        $display("and four idling mixes; %0d mismatches", n_bad);
        if (n_bad == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
